/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define CE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define CE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/cenum_pkg.sv */
package cenum_pkg;

   localparam int RESULT_LIMIT = 8;

   localparam int INDEX_W    = 3;
   localparam int PART_W     = 8;
   localparam int NPARTS_W   = 4;
   localparam int TOTAL_W    = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_PARTS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOTAL     = 2'd1;

   localparam logic [NPARTS_W-1:0] NUM_PARTS_RESET = 4'd2;
   localparam logic [TOTAL_W-1:0]  TOTAL_RESET     = 8'd1;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic start;     // new item: set the final flag, index to zero
      logic load;      // reload the first vector
      logic scan;      // read the next part for the final test
      logic rewind;    // index back to zero before emission
      logic emit;      // emission pipeline runs
      logic set_end;   // the vector just emitted was the last one
      logic rd_last;   // read the last part
      logic rd_cur;    // read the part under the clamped cursor
      logic dec_cur;   // write the cursor part minus one
      logic wr_next;   // write the next part, move the cursor right
      logic clr_last;  // clear the last part
      logic inc_last;  // write the last part plus one
      logic walk;      // move the cursor left and read that part
      logic walk_cap;  // capture the part read by a walk step
   } cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic at_end;
      logic fin;
      logic scan_last;
      logic emit_done;
      logic cur_lt_pen;
      logic walk_stop;
   } sts_type;

endpackage

/* src/cenum_ctrl.sv */
module cenum_ctrl
   import cenum_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_restart,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_SCAN_W = 4'd2;
   localparam logic [3:0] S_EMIT   = 4'd3;
   localparam logic [3:0] S_ADV_A  = 4'd4;
   localparam logic [3:0] S_ADV_B  = 4'd5;
   localparam logic [3:0] S_ADV_C  = 4'd6;
   localparam logic [3:0] S_ADV_D  = 4'd7;
   localparam logic [3:0] S_ADV_E  = 4'd8;
   localparam logic [3:0] S_ADV_F  = 4'd9;
   localparam logic [3:0] S_WALK   = 4'd10;
   localparam logic [3:0] S_WALK_W = 4'd11;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               cmd.load  = req_restart || sts.at_end;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = S_SCAN_W;
            end
         end
         S_SCAN_W: begin
            cmd.rewind = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.emit_done) begin
               if (sts.fin) begin
                  cmd.set_end = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  state_in = S_ADV_A;
               end
            end
         end
         S_ADV_A: begin
            cmd.rd_last = 1'b1;
            state_in    = S_ADV_B;
         end
         S_ADV_B: begin
            cmd.rd_cur = 1'b1;
            state_in   = S_ADV_C;
         end
         S_ADV_C: begin
            cmd.dec_cur = 1'b1;
            state_in    = sts.cur_lt_pen ? S_ADV_D : S_ADV_F;
         end
         S_ADV_D: begin
            cmd.wr_next = 1'b1;
            state_in    = S_ADV_E;
         end
         S_ADV_E: begin
            cmd.clr_last = 1'b1;
            state_in     = S_IDLE;
         end
         S_ADV_F: begin
            cmd.inc_last = 1'b1;
            state_in     = S_WALK;
         end
         S_WALK: begin
            if (sts.walk_stop) begin
               state_in = S_IDLE;
            end else begin
               cmd.walk = 1'b1;
               state_in = S_WALK_W;
            end
         end
         S_WALK_W: begin
            cmd.walk_cap = 1'b1;
            state_in     = S_WALK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* src/cenum_dp.sv */
module cenum_dp
   import cenum_pkg::*;
#(
   parameter int MAX_PARTS  = 8,
   parameter int VALUE_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic                  csr_valid,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_tready,
   output logic                  rsp_valid,
   output logic [INDEX_W-1:0]    rsp_part_index,
   output logic [PART_W-1:0]     rsp_part_value,
   output logic                  rsp_last_part,
   output logic                  rsp_final_vector
);

   localparam int DEPTH = (MAX_PARTS < RESULT_LIMIT) ? MAX_PARTS : RESULT_LIMIT;
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [NPARTS_W-1:0]   DEPTH_N   = NPARTS_W'(DEPTH);
   localparam logic [VALUE_BITS-1:0] RESET_P0  = VALUE_BITS'(TOTAL_RESET);
   localparam logic [VALUE_BITS-1:0] ONE_V     = VALUE_BITS'(1);

   // Configuration registers.
   logic [NPARTS_W-1:0] num_parts_ff, num_parts_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;

   // Part store: single write port, one registered read per cycle.
   logic [VALUE_BITS-1:0] parts_mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff, valid_in;
   logic [VALUE_BITS-1:0] rdata_ff;
   logic                  rvld_ff;
   logic                  rzero_ff;

   logic [2:0]            cursor_ff, cursor_in;
   logic                  at_end_ff, at_end_in;
   logic                  fin_ff, fin_in;
   logic                  chk_ff;
   logic                  dv_ff, dv_in;
   logic                  iss_done_ff, iss_done_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      didx_ff;
   logic [VALUE_BITS-1:0] lastv_ff, lastv_in;
   logic [VALUE_BITS-1:0] cv_ff, cv_in;

   logic                  out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0]    out_idx_ff;
   logic [PART_W-1:0]     out_val_ff;
   logic                  out_last_ff;
   logic                  out_fin_ff;

   logic [IDX_W-1:0]      last_idx, pen_idx, cur_idx, cur_clamp;
   logic [VALUE_BITS-1:0] rval;
   logic                  out_free, load_out, issue;
   logic                  rd_en, we;
   logic [IDX_W-1:0]      raddr, waddr;
   logic [VALUE_BITS-1:0] wdata;

   // Active part count clamped to 2..DEPTH, kept as the index of the last part.
   always_comb begin
      if (num_parts_ff < NUM_PARTS_RESET) begin
         last_idx = IDX_W'(1);
      end else if (num_parts_ff > DEPTH_N) begin
         last_idx = IDX_W'(DEPTH - 1);
      end else begin
         last_idx = IDX_W'(num_parts_ff - NPARTS_W'(1));
      end
   end

   assign pen_idx   = last_idx - IDX_W'(1);
   assign cur_idx   = cursor_ff[IDX_W-1:0];
   assign cur_clamp = (cursor_ff > 3'(pen_idx)) ? pen_idx : cur_idx;

   // An entry never written since reset or reload reads as its reset value.
   assign rval = rvld_ff ? rdata_ff : (rzero_ff ? RESET_P0 : '0);

   assign out_free = !out_valid_ff || rsp_tready;
   assign load_out = cmd.emit && dv_ff && out_free;
   assign issue    = cmd.emit && !iss_done_ff && (!dv_ff || load_out);

   always_comb begin
      rd_en = 1'b0;
      raddr = idx_ff;
      if (cmd.scan || issue) begin
         rd_en = 1'b1;
         raddr = idx_ff;
      end else if (cmd.rd_last) begin
         rd_en = 1'b1;
         raddr = last_idx;
      end else if (cmd.rd_cur) begin
         rd_en = 1'b1;
         raddr = cur_clamp;
      end else if (cmd.walk) begin
         rd_en = 1'b1;
         raddr = cur_idx - IDX_W'(1);
      end
   end

   always_comb begin
      we    = 1'b0;
      waddr = '0;
      wdata = '0;
      if (cmd.load) begin
         we    = 1'b1;
         waddr = '0;
         wdata = VALUE_BITS'(total_ff);
      end else if (cmd.dec_cur) begin
         we    = 1'b1;
         waddr = cur_idx;
         wdata = rval - ONE_V;
      end else if (cmd.wr_next) begin
         we    = 1'b1;
         waddr = cur_idx + IDX_W'(1);
         wdata = lastv_ff + ONE_V;
      end else if (cmd.clr_last) begin
         we    = 1'b1;
         waddr = last_idx;
         wdata = '0;
      end else if (cmd.inc_last) begin
         we    = 1'b1;
         waddr = last_idx;
         wdata = lastv_ff + ONE_V;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load) begin
         valid_in = '0;
      end
      if (we) begin
         valid_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         parts_mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= parts_mem[raddr];
         rvld_ff  <= valid_ff[raddr];
         rzero_ff <= (raddr == '0);
      end
   end

   always_comb begin
      num_parts_in = num_parts_ff;
      total_in     = total_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_PARTS: num_parts_in = csr_data[NPARTS_W-1:0];
            CSR_TOTAL:     total_in     = csr_data[TOTAL_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.start || cmd.rewind) begin
         idx_in = '0;
      end else if (cmd.scan || issue) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      fin_in = fin_ff;
      if (cmd.start) begin
         fin_in = 1'b1;
      end else if (chk_ff) begin
         fin_in = fin_ff && (rval == '0);
      end

      dv_in = dv_ff;
      if (issue) begin
         dv_in = 1'b1;
      end else if (load_out) begin
         dv_in = 1'b0;
      end

      iss_done_in = iss_done_ff;
      if (cmd.rewind) begin
         iss_done_in = 1'b0;
      end else if (issue && (idx_ff == last_idx)) begin
         iss_done_in = 1'b1;
      end

      at_end_in = at_end_ff;
      if (cmd.load) begin
         at_end_in = 1'b0;
      end else if (cmd.set_end) begin
         at_end_in = 1'b1;
      end

      cursor_in = cursor_ff;
      if (cmd.load) begin
         cursor_in = '0;
      end else if (cmd.rd_cur) begin
         cursor_in = 3'(cur_clamp);
      end else if (cmd.wr_next) begin
         cursor_in = cursor_ff + 3'd1;
      end else if (cmd.walk) begin
         cursor_in = cursor_ff - 3'd1;
      end

      lastv_in = cmd.rd_cur ? rval : lastv_ff;

      cv_in = cv_ff;
      if (cmd.dec_cur) begin
         cv_in = rval - ONE_V;
      end else if (cmd.walk_cap) begin
         cv_in = rval;
      end

      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_parts_ff <= NUM_PARTS_RESET;
         total_ff     <= TOTAL_RESET;
         valid_ff     <= '0;
         cursor_ff    <= '0;
         at_end_ff    <= 1'b0;
         fin_ff       <= 1'b0;
         chk_ff       <= 1'b0;
         dv_ff        <= 1'b0;
         iss_done_ff  <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         num_parts_ff <= num_parts_in;
         total_ff     <= total_in;
         valid_ff     <= valid_in;
         cursor_ff    <= cursor_in;
         at_end_ff    <= at_end_in;
         fin_ff       <= fin_in;
         chk_ff       <= cmd.scan;
         dv_ff        <= dv_in;
         iss_done_ff  <= iss_done_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lastv_ff <= lastv_in;
      cv_ff    <= cv_in;
      if (issue) begin
         didx_ff <= idx_ff;
      end
      if (load_out) begin
         out_idx_ff  <= INDEX_W'(didx_ff);
         out_val_ff  <= PART_W'(rval);
         out_last_ff <= (didx_ff == last_idx);
         out_fin_ff  <= fin_ff;
      end
   end

   assign sts.at_end     = at_end_ff;
   assign sts.fin        = fin_ff;
   assign sts.scan_last  = (idx_ff == pen_idx);
   assign sts.emit_done  = iss_done_ff && !dv_ff;
   assign sts.cur_lt_pen = (cursor_ff < 3'(pen_idx));
   assign sts.walk_stop  = (cv_ff != '0) || (cursor_ff == '0);

   assign rsp_valid        = out_valid_ff;
   assign rsp_part_index   = out_idx_ff;
   assign rsp_part_value   = out_val_ff;
   assign rsp_last_part    = out_last_ff;
   assign rsp_final_vector = out_fin_ff;

endmodule

/* src/composition_enumerator.sv */
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tdata: restart
// rsp      out        rsp_tvalid/rsp_tready   tdata: part_index, part_value; tlast; tuser
// csr      in         csr_valid/csr_ready     csr_index, csr_data
//
// Each item is paced by the single-port part store, one read per cycle, and by
// the cursor's walk back over parts; a new request is taken only once the last
// item is done, and the final vector skips the step to the next one.
// Reset clears control state only; the parts read as the first vector at once,
// through per-entry valid bits, so there is no clearing pass.
// A low rsp_tready holds the result register and pauses emission.
module composition_enumerator
   import cenum_pkg::*;
#(
   parameter int MAX_PARTS  = 8,
   parameter int VALUE_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] restart
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] part_index, [10:3] part_value
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,   // [0] final_vector
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type             cmd;
   sts_type             sts;
   logic [INDEX_W-1:0]  part_index;
   logic [PART_W-1:0]   part_value;

   assign csr_ready = 1'b1;

   cenum_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_restart (req_tdata[0]),
      .req_tready  (req_tready),
      .sts         (sts),
      .cmd         (cmd)
   );

   cenum_dp #(
      .MAX_PARTS  (MAX_PARTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_tready       (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_part_index   (part_index),
      .rsp_part_value   (part_value),
      .rsp_last_part    (rsp_tlast),
      .rsp_final_vector (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W - PART_W - INDEX_W){1'b0}}, part_value, part_index};

endmodule

/* src/cenum_checker.sv */
`include "assert_macros.svh"

module cenum_checker
   import cenum_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  rsp_tuser
);

   logic [INDEX_W-1:0] exp_idx_ff;
   logic               mid_ff;
   logic               prev_fin_ff;

   // Tracks the position within the vector now leaving the block.
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff  <= '0;
         mid_ff      <= 1'b0;
         prev_fin_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (rsp_tlast) begin
            exp_idx_ff <= '0;
            mid_ff     <= 1'b0;
         end else begin
            exp_idx_ff  <= exp_idx_ff + INDEX_W'(1);
            mid_ff      <= 1'b1;
            prev_fin_ff <= rsp_tuser;
         end
      end
   end

   `CE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "result item changed while stalled")

   `CE_ASSERT_IMP(a_part_order, clock, reset, rsp_tvalid, rsp_tdata[INDEX_W-1:0] == exp_idx_ff, "parts out of order")

   `CE_ASSERT_IMP(a_final_steady, clock, reset, rsp_tvalid && mid_ff, rsp_tuser == prev_fin_ff, "final mark changed within a vector")

   `CE_ASSERT_IMP(a_final_zero, clock, reset, rsp_tvalid && rsp_tuser && !rsp_tlast, rsp_tdata[INDEX_W+PART_W-1:INDEX_W] == '0, "nonzero leading part in final vector")

endmodule

bind composition_enumerator cenum_checker u_cenum_checker (.*);

/* test/tb_composition_enumerator.sv */
`timescale 1ns / 1ps

module tb_composition_enumerator;
   import cenum_pkg::*;

   localparam int SHADOW_PARTS  = 8;
   localparam int SETTLE_CYCLES = 48;
   localparam int QUIET_LIMIT   = 1500;
   localparam int RANDOM_ITEMS  = 205;
   localparam int SCRIPT_ROWS   = 37;

   // Register indexes with no register behind them; writes there change nothing.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum logic [1:0] {
      ROW_CFG,
      ROW_REQ
   } row_kind_type;

   // A request row with typed set carries its whole expected vector, part 0 in
   // the lowest byte; every other request row is checked against the predictor.
   typedef struct packed {
      row_kind_type          kind;
      logic                  restart;
      logic                  typed;
      logic [3:0]            count;
      logic                  fin;
      logic [63:0]           parts;
      logic [CSR_ADDR_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0] value;
   } script_row_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [PART_W-1:0]  value;
      logic               last;
      logic               fin;
   } part_result_type;

   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{ROW_REQ, 1'b0, 1'b1, 4'd2, 1'b0, 64'h0001, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b1, 4'd2, 1'b1, 64'h0100, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b1, 4'd2, 1'b0, 64'h0001, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b1, 1'b1, 4'd2, 1'b0, 64'h0001, CSR_NUM_PARTS, 8'h00},
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'd8},
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_TOTAL,     8'd255},
      '{ROW_REQ, 1'b1, 1'b1, 4'd8, 1'b0, 64'h00ff, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'd0},
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_TOTAL,     8'd0},
      '{ROW_REQ, 1'b1, 1'b1, 4'd2, 1'b1, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b1, 4'd2, 1'b1, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'd4},
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_TOTAL,     8'd2},
      '{ROW_REQ, 1'b1, 1'b1, 4'd4, 1'b0, 64'h0002, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      // Shrinking the vector mid-sequence drops the value held in the last part,
      // so the remaining requests walk what is left to the final vector.
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'd3},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'hff},
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_SPARE_A,   8'haa},
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_SPARE_B,   8'h55},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'd3},
      '{ROW_CFG, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_TOTAL,     8'd2},
      '{ROW_REQ, 1'b1, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00},
      '{ROW_REQ, 1'b0, 1'b0, 4'd0, 1'b0, 64'h0000, CSR_NUM_PARTS, 8'h00}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the enumerator state and its registers.
   logic [NPARTS_W-1:0] cfg_parts;
   logic [TOTAL_W-1:0]  cfg_total;
   logic [PART_W-1:0]   shadow_parts [SHADOW_PARTS];
   logic [INDEX_W-1:0]  shadow_cursor;
   bit                  shadow_at_end;

   part_result_type expected_parts [$];
   int              failures = 0;
   int              quiet_cycles = 0;
   int              rsp_stall = 0;
   bit              rsp_steady = 1'b0;
   bit              req_steady = 1'b0;
   bit              sent_since_idle = 1'b0;

   composition_enumerator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int rand_gap(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void reload_first();
      for (int i = 0; i < SHADOW_PARTS; i++) shadow_parts[i] = '0;
      shadow_parts[0] = cfg_total;
      shadow_cursor = '0;
      shadow_at_end = 1'b0;
   endfunction

   // Produces the vector that one request emits and steps the shadow state on.
   function automatic void next_vector(input logic restart, output logic [63:0] vals,
                                       output int n, output bit fin);
      int pen;
      int c;
      n = int'(cfg_parts);
      if (n < 2) n = 2;
      if (n > SHADOW_PARTS) n = SHADOW_PARTS;
      if (restart || shadow_at_end) reload_first();
      fin = 1'b1;
      for (int i = 0; i < n - 1; i++)
         if (shadow_parts[i] != '0) fin = 1'b0;
      vals = '0;
      for (int i = 0; i < n; i++) vals[8*i +: 8] = shadow_parts[i];
      if (fin) begin
         shadow_at_end = 1'b1;
         return;
      end
      pen = n - 2;
      c = int'(shadow_cursor);
      if (c > pen) c = pen;
      shadow_parts[c] = shadow_parts[c] - 1'b1;
      if (c < pen) begin
         c++;
         shadow_parts[c] = shadow_parts[n-1] + 1'b1;
         shadow_parts[n-1] = '0;
      end else begin
         shadow_parts[n-1] = shadow_parts[n-1] + 1'b1;
         while (shadow_parts[c] == '0 && c != 0) c--;
      end
      shadow_cursor = c[INDEX_W-1:0];
   endfunction

   function automatic void expect_vector(logic [63:0] vals, int n, bit fin);
      part_result_type r;
      for (int i = 0; i < n; i++) begin
         r.index = i[INDEX_W-1:0];
         r.value = vals[8*i +: 8];
         r.last  = (i == n - 1);
         r.fin   = fin;
         expected_parts.push_back(r);
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      failures++;
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic push_request(input logic restart, input bit typed, input int typed_count,
                               input bit typed_fin, input logic [63:0] typed_parts);
      int          gap;
      int          n;
      bit          fin;
      logic [63:0] vals;
      gap = rand_gap(req_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(restart);
      do @(posedge clock); while (!req_tready);
      next_vector(restart, vals, n, fin);
      if (typed) expect_vector(typed_parts, typed_count, typed_fin);
      else expect_vector(vals, n, fin);
      sent_since_idle = 1'b1;
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_NUM_PARTS: cfg_parts = data[NPARTS_W-1:0];
         CSR_TOTAL:     cfg_total = data[TOTAL_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // The block may still be stepping to the next vector after its last part
   // went out, so the settle time covers a full item with a long walk back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_parts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      sent_since_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_stall <= rand_gap(rsp_steady);
      end
      if ($urandom_range(0, 299) == 0) rsp_steady <= !rsp_steady;
   end

   always @(posedge clock) begin
      part_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_parts.size() == 0) begin
            report_mismatch("result item with none expected", int'(rsp_tdata), 0);
         end else begin
            want = expected_parts.pop_front();
            if (rsp_tdata[INDEX_W-1:0] != want.index)
               report_mismatch("part_index", int'(rsp_tdata[INDEX_W-1:0]), int'(want.index));
            if (rsp_tdata[INDEX_W +: PART_W] != want.value)
               report_mismatch("part_value", int'(rsp_tdata[INDEX_W +: PART_W]),
                               int'(want.value));
            if (rsp_tlast != want.last)
               report_mismatch("last_part", int'(rsp_tlast), int'(want.last));
            if (rsp_tuser != want.fin)
               report_mismatch("final_vector", int'(rsp_tuser), int'(want.fin));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int                    random_items;
      int                    phase_len;
      int                    r;
      bit                    order;
      logic                  restart;
      logic [CSR_ADDR_W-1:0] idx;
      logic [NPARTS_W-1:0]   new_parts;
      logic [TOTAL_W-1:0]    new_total;

      cfg_parts = NUM_PARTS_RESET;
      cfg_total = TOTAL_RESET;
      reload_first();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (SCRIPT[k]) begin
         if (SCRIPT[k].kind == ROW_CFG) begin
            if (sent_since_idle) wait_drained();
            write_csr(SCRIPT[k].reg_index, SCRIPT[k].value);
         end else begin
            push_request(SCRIPT[k].restart, SCRIPT[k].typed, int'(SCRIPT[k].count),
                         SCRIPT[k].fin, SCRIPT[k].parts);
         end
      end

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_drained();
         req_steady = ($urandom_range(0, 3) == 0);

         // Mostly small vectors and totals so that whole enumerations wrap around.
         r = $urandom_range(0, 99);
         if (r < 65) new_parts = NPARTS_W'($urandom_range(2, 4));
         else if (r < 85) new_parts = NPARTS_W'($urandom_range(5, 8));
         else new_parts = NPARTS_W'($urandom_range(0, 15));
         r = $urandom_range(0, 99);
         if (r < 60) new_total = TOTAL_W'($urandom_range(1, 6));
         else if (r < 80) new_total = TOTAL_W'($urandom_range(7, 24));
         else if (r < 90) new_total = '0;
         else new_total = TOTAL_W'($urandom_range(0, 255));

         order = 1'($urandom_range(0, 1));
         for (int k = 0; k < 2; k++) begin
            idx = ((k[0] ^ order) != 0) ? CSR_TOTAL : CSR_NUM_PARTS;
            if ($urandom_range(0, 4) != 0) begin
               if (idx == CSR_TOTAL) write_csr(idx, new_total);
               else write_csr(idx, {4'($urandom_range(0, 15)), new_parts});
            end
         end
         if ($urandom_range(0, 7) == 0)
            write_csr(($urandom_range(0, 1) != 0) ? CSR_SPARE_A : CSR_SPARE_B,
                      CSR_DATA_W'($urandom_range(0, 255)));

         phase_len = $urandom_range(8, 30);
         for (int j = 0; j < phase_len && random_items < RANDOM_ITEMS; j++) begin
            if (j == 0) restart = ($urandom_range(0, 4) != 0);
            else restart = ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 24) == 0) begin
               // Hold off until every expected part has come back.
               req_tvalid <= 1'b0;
               do @(posedge clock); while (expected_parts.size() != 0);
            end
            push_request(restart, 1'b0, 0, 1'b0, '0);
            random_items++;
         end
      end

      wait_drained();
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
